>>> src/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg: shared constants for the ray/box slab intersection block
// Face codes, fixed-point format and the register map.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FACE_W    = 3;
  localparam int REG_IDX_W = 3;

  typedef logic [FACE_W-1:0]    face_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam face_t FACE_MIN_X = 3'd0;
  localparam face_t FACE_MAX_X = 3'd1;
  localparam face_t FACE_MIN_Y = 3'd2;
  localparam face_t FACE_MAX_Y = 3'd3;
  localparam face_t FACE_MIN_Z = 3'd4;
  localparam face_t FACE_MAX_Z = 3'd5;

  // The open side of the box: never reported
  localparam face_t FACE_OPEN = FACE_MIN_Y;

  localparam reg_idx_t REG_BOX_MIN_X = 3'd0;
  localparam reg_idx_t REG_BOX_MAX_X = 3'd1;
  localparam reg_idx_t REG_BOX_MIN_Y = 3'd2;
  localparam reg_idx_t REG_BOX_MAX_Y = 3'd3;
  localparam reg_idx_t REG_BOX_MIN_Z = 3'd4;
  localparam reg_idx_t REG_BOX_MAX_Z = 3'd5;

endpackage

>>> src/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div: pipelined signed divider with saturation
// Restoring division, one quotient bit per stage, then sign and clamp.
// ----------------------------------------------------------------------------
module rbsi_div #(
  parameter int W  = 32,
  parameter int NW = 49
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NW-1:0]       num_mag,
  input  logic [W-1:0]        den_mag,
  input  logic                neg,
  output logic signed [W-1:0] quo
);
  import rbsi_pkg::*;

  logic [W-1:0]  rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [W-1:0]  den_r [NW];
  logic          neg_r [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [W-1:0]  rem_i;
    logic [NW-1:0] num_i;
    logic [NW-1:0] quo_i;
    logic [W-1:0]  den_i;
    logic          neg_i;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_i = '0;
      assign num_i = num_mag;
      assign quo_i = '0;
      assign den_i = den_mag;
      assign neg_i = neg;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign num_i = num_r[s-1];
      assign quo_i = quo_r[s-1];
      assign den_i = den_r[s-1];
      assign neg_i = neg_r[s-1];
    end

    assign trial = {rem_i, num_i[NW-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[W-1:0] : trial[W-1:0];
        num_r[s] <= num_i << 1;
        quo_r[s] <= {quo_i[NW-2:0], ge};
        den_r[s] <= den_i;
        neg_r[s] <= neg_i;
      end
    end
  end

  localparam logic [NW-1:0] MAG_POS = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NW-1:0] MAG_NEG = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic [NW-1:0]       q_mag;
  logic signed [W-1:0] quo_next;

  assign q_mag = quo_r[NW-1];

  always_comb begin
    if (neg_r[NW-1]) begin
      quo_next = (q_mag > MAG_NEG) ? MAG_NEG[W-1:0] : (~q_mag[W-1:0] + 1'b1);
    end else begin
      quo_next = (q_mag > MAG_POS) ? MAG_POS[W-1:0] : q_mag[W-1:0];
    end
  end

  // Clamp stage
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= quo_next;
    end
  end

endmodule

>>> src/rbsi_clip.sv
// ----------------------------------------------------------------------------
// rbsi_clip: slab merge and face selection
// Merge the three slab intervals, then pick the entry or exit face.
// ----------------------------------------------------------------------------
module rbsi_clip #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] t_near [3],
  input  logic signed [W-1:0] t_far  [3],
  input  logic [2:0]          dir_zero,
  input  logic [2:0]          slab_miss,
  input  logic [2:0]          dir_neg,
  input  logic signed [W-1:0] tmin,
  input  logic signed [W-1:0] tmax,
  output logic                hit,
  output rbsi_pkg::face_t     hit_face,
  output logic signed [W-1:0] new_tmax
);
  import rbsi_pkg::*;

  logic signed [W-1:0] t_in, t_out, t_in_r, t_out_r, tmin_r, tmax_r;
  face_t               f_in, f_out, f_in_r, f_out_r;
  logic                in_ok, out_ok, miss, miss_r;

  always_comb begin
    t_in   = '0;
    t_out  = '0;
    f_in   = FACE_MIN_X;
    f_out  = FACE_MIN_X;
    in_ok  = 1'b0;
    out_ok = 1'b0;
    miss   = |slab_miss;
    for (int a = 0; a < 3; a++) begin
      if (!dir_zero[a]) begin
        if (!in_ok || t_near[a] > t_in) begin
          t_in  = t_near[a];
          f_in  = face_t'(2 * a) | face_t'(dir_neg[a]);
          in_ok = 1'b1;
        end
        if (!out_ok || t_far[a] < t_out) begin
          t_out  = t_far[a];
          f_out  = face_t'(2 * a) | face_t'(!dir_neg[a]);
          out_ok = 1'b1;
        end
      end
    end
    if (!in_ok || !out_ok || t_in > t_out) begin
      miss = 1'b1;
    end
  end

  // Merge stage
  always_ff @(posedge clk) begin
    if (en) begin
      t_in_r  <= t_in;
      t_out_r <= t_out;
      f_in_r  <= f_in;
      f_out_r <= f_out;
      miss_r  <= miss;
      tmin_r  <= tmin;
      tmax_r  <= tmax;
    end
  end

  // Select stage: entry face first, exit face as fallback
  always_ff @(posedge clk) begin
    if (en) begin
      hit      <= 1'b0;
      hit_face <= FACE_MIN_X;
      new_tmax <= tmax_r;
      if (!miss_r) begin
        if (f_in_r != FACE_OPEN && tmin_r < t_in_r && t_in_r < tmax_r) begin
          hit      <= 1'b1;
          hit_face <= f_in_r;
          new_tmax <= t_in_r;
        end else if (f_out_r != FACE_OPEN && tmin_r < t_out_r && t_out_r < tmax_r) begin
          hit      <= 1'b1;
          hit_face <= f_out_r;
          new_tmax <= t_out_r;
        end
      end
    end
  end

endmodule

>>> src/ray_box_slab_intersect_top.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top: ray versus axis-aligned box, slab method
// Clips each ray word against the configured box in signed Q16.16.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless the output stalls; the six per-ray
// slab divisions run in six restoring divider lanes of COORD_WIDTH + 17
// stages, one quotient bit each.
// A stalled output freezes the whole pipe; nothing is lost or repeated.
// Reset: clears all valid bits and loads the box to -1.0 .. +1.0 on each axis.
module ray_box_slab_intersect_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  rbsi_pkg::reg_idx_t            wr_index,
  input  logic [COORD_WIDTH-1:0]        wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic signed [COORD_WIDTH-1:0] ray_tmin,
  input  logic signed [COORD_WIDTH-1:0] ray_tmax,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output rbsi_pkg::face_t               hit_face,
  output logic signed [COORD_WIDTH-1:0] new_tmax
);
  import rbsi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int NW = W + FRAC_BITS + 1;   // numerator magnitude width
  localparam int DL = NW + 1;              // divider latency
  localparam int P  = 1 + DL + 2;          // total pipe depth

  localparam logic signed [W-1:0] ONE     = W'(65536);
  localparam logic signed [W-1:0] NEG_ONE = -ONE;

  // Box registers
  logic signed [W-1:0] box_lo [3];
  logic signed [W-1:0] box_hi [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] <= NEG_ONE;
        box_hi[a] <= ONE;
      end
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BOX_MIN_X: box_lo[0] <= wr_data;
        REG_BOX_MAX_X: box_hi[0] <= wr_data;
        REG_BOX_MIN_Y: box_lo[1] <= wr_data;
        REG_BOX_MAX_Y: box_hi[1] <= wr_data;
        REG_BOX_MIN_Z: box_lo[2] <= wr_data;
        REG_BOX_MAX_Z: box_hi[2] <= wr_data;
        default: ;   // drop writes beyond the map
      endcase
    end
  end

  // Pipe control: advance all stages together unless the output word waits
  logic [P-1:0] pipe_v;
  logic         en;

  assign en        = !pipe_v[P-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = pipe_v[P-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_v <= '0;
    end else if (en) begin
      pipe_v <= {pipe_v[P-2:0], in_valid};
    end
  end

  // Set-up stage: slab numerators, divisor magnitudes and slab checks
  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];

  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  logic [NW-1:0]       s1_num [6];   // near at 2a, far at 2a+1
  logic                s1_neg [6];
  logic [W-1:0]        s1_den [3];
  logic [2:0]          s1_dz, s1_miss, s1_dneg;
  logic signed [W-1:0] s1_tmin, s1_tmax;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        logic                 dneg;
        logic signed [W:0]    dn, df;
        logic signed [NW-1:0] nn, nf;
        dneg = dir[a][W-1];
        dn   = (dneg ? (W+1)'(box_hi[a]) : (W+1)'(box_lo[a])) - (W+1)'(org[a]);
        df   = (dneg ? (W+1)'(box_lo[a]) : (W+1)'(box_hi[a])) - (W+1)'(org[a]);
        nn   = NW'(dn) <<< FRAC_BITS;
        nf   = NW'(df) <<< FRAC_BITS;
        s1_num[2*a]   <= nn[NW-1] ? -nn : nn;
        s1_num[2*a+1] <= nf[NW-1] ? -nf : nf;
        s1_neg[2*a]   <= nn[NW-1] ^ dneg;
        s1_neg[2*a+1] <= nf[NW-1] ^ dneg;
        s1_den[a]     <= (dir[a] == '0) ? W'(1) : (dneg ? -dir[a] : dir[a]);
        s1_dz[a]      <= dir[a] == '0;
        s1_miss[a]    <= (dir[a] == '0) && (org[a] < box_lo[a] || org[a] > box_hi[a]);
        s1_dneg[a]    <= dneg;
      end
      s1_tmin <= ray_tmin;
      s1_tmax <= ray_tmax;
    end
  end

  // Divider lanes
  logic signed [W-1:0] t_near [3];
  logic signed [W-1:0] t_far  [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_div #(.W(W), .NW(NW)) u_div_near (
      .clk(clk), .en(en), .num_mag(s1_num[2*a]), .den_mag(s1_den[a]),
      .neg(s1_neg[2*a]), .quo(t_near[a])
    );
    rbsi_div #(.W(W), .NW(NW)) u_div_far (
      .clk(clk), .en(en), .num_mag(s1_num[2*a+1]), .den_mag(s1_den[a]),
      .neg(s1_neg[2*a+1]), .quo(t_far[a])
    );
  end

  // Sideband delay line alongside the dividers
  logic [2:0]          sb_dz   [DL];
  logic [2:0]          sb_miss [DL];
  logic [2:0]          sb_dneg [DL];
  logic signed [W-1:0] sb_tmin [DL];
  logic signed [W-1:0] sb_tmax [DL];

  always_ff @(posedge clk) begin
    if (en) begin
      sb_dz[0]   <= s1_dz;
      sb_miss[0] <= s1_miss;
      sb_dneg[0] <= s1_dneg;
      sb_tmin[0] <= s1_tmin;
      sb_tmax[0] <= s1_tmax;
      for (int k = 1; k < DL; k++) begin
        sb_dz[k]   <= sb_dz[k-1];
        sb_miss[k] <= sb_miss[k-1];
        sb_dneg[k] <= sb_dneg[k-1];
        sb_tmin[k] <= sb_tmin[k-1];
        sb_tmax[k] <= sb_tmax[k-1];
      end
    end
  end

  // Merge and select, two stages, final one is the output register
  rbsi_clip #(.W(W)) u_clip (
    .clk(clk), .en(en),
    .t_near(t_near), .t_far(t_far),
    .dir_zero(sb_dz[DL-1]), .slab_miss(sb_miss[DL-1]), .dir_neg(sb_dneg[DL-1]),
    .tmin(sb_tmin[DL-1]), .tmax(sb_tmax[DL-1]),
    .hit(hit), .hit_face(hit_face), .new_tmax(new_tmax)
  );

  // Checks
  a_miss_face_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_face == FACE_MIN_X)
    else $error("miss word carries a non-zero face");

  a_open_face: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> hit_face != FACE_OPEN)
    else $error("open side reported as hit");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit_face <= FACE_MAX_Z)
    else $error("face code out of range");

endmodule

>>> tb/ray_box_slab_intersect_top_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_top_test: self-checking bench for the slab clipper
// Drives ray words through valid/ready with random gaps, predicts each result
// from the box registers and compares every output word in order.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_top_test;
  import rbsi_pkg::*;

  localparam int CW        = 32;
  localparam int LATENCY   = CW + 21;
  localparam int WATCHDOG  = 20000;
  localparam int NUM_RAND  = 1200;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t ox, oy, oz, dx, dy, dz, tmin, tmax;
  } ray_t;

  typedef struct packed {
    logic   hit;
    face_t  face;
    coord_t tmax;
  } clip_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  reg_idx_t wr_index = REG_BOX_MIN_X;
  logic [CW-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t origin_x = '0, origin_y = '0, origin_z = '0;
  coord_t dir_x = '0, dir_y = '0, dir_z = '0;
  coord_t ray_tmin = '0, ray_tmax = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  face_t hit_face;
  coord_t new_tmax;

  ray_box_slab_intersect_top #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .ray_tmin(ray_tmin), .ray_tmax(ray_tmax),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit(hit), .hit_face(hit_face), .new_tmax(new_tmax)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the box, index order matches the register map
  coord_t box_bound [6];
  clip_t  pending_clips [$];
  int     mismatches = 0;
  int     words_checked = 0;
  int     hits_seen = 0;
  int     idle_cycles = 0;
  bit     hold_output = 1'b0;
  bit     timed_out = 1'b0;

  // Saturating slab distance: ((bound - origin) << 16) / dir, truncated
  function automatic coord_t slab_distance(coord_t bound, coord_t org, coord_t dir);
    logic signed [63:0] num, quo;
    num = (64'(bound) - 64'(org)) * 64'sd65536;
    quo = num / 64'(dir);
    if (quo > 64'sd2147483647) return 32'sh7fffffff;
    if (quo < -64'sd2147483648) return 32'sh80000000;
    return quo[CW-1:0];
  endfunction

  function automatic clip_t clip_ray(ray_t r);
    coord_t org [3], dir [3];
    coord_t t_enter, t_leave, near_t, far_t, lo, hi;
    face_t  f_enter, f_leave, near_f, far_f;
    bit     have_enter, have_leave, missed;
    clip_t  res;
    org = '{r.ox, r.oy, r.oz};
    dir = '{r.dx, r.dy, r.dz};
    t_enter = '0; t_leave = '0; f_enter = FACE_MIN_X; f_leave = FACE_MIN_X;
    have_enter = 0; have_leave = 0; missed = 0;
    for (int ax = 0; ax < 3; ax++) begin
      lo = box_bound[2*ax];
      hi = box_bound[2*ax+1];
      if (dir[ax] == 0) begin
        if (org[ax] < lo || org[ax] > hi) missed = 1;
        continue;
      end
      if (dir[ax] > 0) begin
        near_t = slab_distance(lo, org[ax], dir[ax]); near_f = face_t'(2*ax);
        far_t  = slab_distance(hi, org[ax], dir[ax]); far_f  = face_t'(2*ax+1);
      end else begin
        near_t = slab_distance(hi, org[ax], dir[ax]); near_f = face_t'(2*ax+1);
        far_t  = slab_distance(lo, org[ax], dir[ax]); far_f  = face_t'(2*ax);
      end
      if (!have_enter || near_t > t_enter) begin
        t_enter = near_t; f_enter = near_f; have_enter = 1;
      end
      if (!have_leave || far_t < t_leave) begin
        t_leave = far_t; f_leave = far_f; have_leave = 1;
      end
    end
    if (!have_enter || !have_leave || t_enter > t_leave) missed = 1;
    res = '{hit: 1'b0, face: FACE_MIN_X, tmax: r.tmax};
    if (!missed) begin
      if (f_enter != FACE_OPEN && r.tmin < t_enter && t_enter < r.tmax)
        res = '{hit: 1'b1, face: f_enter, tmax: t_enter};
      else if (f_leave != FACE_OPEN && r.tmin < t_leave && t_leave < r.tmax)
        res = '{hit: 1'b1, face: f_leave, tmax: t_leave};
    end
    return res;
  endfunction

  // Short gaps mostly, a long one now and then
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  bit sender_gaps = 1'b1;

  // Offer one word, hold it until accepted, record what it should produce.
  // Valid stays high after acceptance so the next word can follow straight
  // on; drop it at the next falling edge when a gap comes or in drain().
  task automatic send_ray(ray_t r);
    int gap;
    gap = sender_gaps ? gap_length() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
    dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
    ray_tmin <= r.tmin; ray_tmax <= r.tmax;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_clips.push_back(clip_ray(r));
  endtask

  task automatic write_box(reg_idx_t idx, coord_t val);
    @(negedge clk);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    box_bound[idx] = val;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_clips.size() != 0 && !timed_out) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic coord_t q16(int whole);
    return coord_t'(whole) <<< 16;
  endfunction

  function automatic coord_t any_coord();
    case ($urandom_range(0, 4))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return coord_t'($signed($urandom_range(0, 64)) - 32);
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return '0;
    endcase
  endfunction

  // Mostly rays aimed through a box of moderate size, the rest noise
  function automatic ray_t random_ray();
    ray_t r;
    if ($urandom_range(0, 3) != 0) begin
      r.ox = coord_t'($signed($urandom_range(0, 12 << 16)) - (6 << 16));
      r.oy = coord_t'($signed($urandom_range(0, 12 << 16)) - (6 << 16));
      r.oz = coord_t'($signed($urandom_range(0, 12 << 16)) - (6 << 16));
      r.dx = ($urandom_range(0, 9) == 0) ? '0 :
             coord_t'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      r.dy = ($urandom_range(0, 9) == 0) ? '0 :
             coord_t'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      r.dz = ($urandom_range(0, 9) == 0) ? '0 :
             coord_t'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      r.tmin = coord_t'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      r.tmax = ($urandom_range(0, 4) == 0) ? 32'sh7fffffff :
               coord_t'($urandom_range(0, 40 << 16));
    end else begin
      r = '{any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
            any_coord(), any_coord(), any_coord()};
    end
    return r;
  endfunction

  task automatic random_box();
    coord_t a, b;
    for (int ax = 0; ax < 3; ax++) begin
      a = coord_t'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      b = coord_t'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      // occasionally leave the bounds inverted
      if (a > b && $urandom_range(0, 7) != 0) begin
        write_box(reg_idx_t'(2*ax), b); write_box(reg_idx_t'(2*ax+1), a);
      end else begin
        write_box(reg_idx_t'(2*ax), a); write_box(reg_idx_t'(2*ax+1), b);
      end
    end
  endtask

  // Directed: each face, axis-parallel rays, origin inside, extremes
  task automatic test_directed();
    coord_t one;
    one = q16(1);
    send_ray('{-q16(5), '0, '0, one, '0, '0, '0, q16(100)});       // enter minX
    send_ray('{q16(5), '0, '0, -one, '0, '0, '0, q16(100)});       // enter maxX
    send_ray('{'0, -q16(5), '0, '0, one, '0, '0, q16(100)});       // open side: exit maxY
    send_ray('{'0, q16(5), '0, '0, -one, '0, '0, q16(100)});       // enter maxY
    send_ray('{'0, '0, -q16(5), '0, '0, one, '0, q16(100)});       // enter minZ
    send_ray('{'0, '0, q16(5), '0, '0, -one, '0, q16(100)});       // enter maxZ
    send_ray('{'0, '0, '0, one, '0, '0, '0, q16(100)});            // inside: exit
    send_ray('{'0, q16(2), '0, one, '0, '0, '0, q16(100)});        // zero dir outside slab
    send_ray('{'0, '0, '0, '0, '0, '0, '0, q16(100)});             // all zero dir
    send_ray('{-q16(5), '0, '0, one, '0, '0, '0, q16(3)});         // beyond tmax
    send_ray('{-q16(5), '0, '0, one, '0, '0, q16(7), q16(100)});   // past tmin
    send_ray('{-q16(5), q16(3), '0, one, one, '0, '0, q16(100)});  // empty interval
    send_ray('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh00000001,
               32'sh00000001, 32'sh00000001, 32'sh80000000, 32'sh7fffffff});
    send_ray('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
               32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff});
    send_ray('{32'sh80000000, '0, '0, 32'sh7fffffff, '0, '0, 32'sh80000000,
               32'sh7fffffff});
    send_ray('{'1, '1, '1, '1, '1, '1, '1, '1});
    send_ray('{-q16(5), 32'sh00010000, '0, one, '0, '0, '0, q16(100)}); // grazing maxY
  endtask

  task automatic test_box_extremes();
    drain();
    write_box(REG_BOX_MIN_X, 32'sh80000000); write_box(REG_BOX_MAX_X, 32'sh7fffffff);
    write_box(REG_BOX_MIN_Y, 32'sh80000000); write_box(REG_BOX_MAX_Y, 32'sh7fffffff);
    write_box(REG_BOX_MIN_Z, 32'sh80000000); write_box(REG_BOX_MAX_Z, 32'sh7fffffff);
    repeat (40) send_ray(random_ray());
    send_ray('{'0, '0, '0, 32'sh00000001, 32'sh80000000, 32'sh7fffffff,
               32'sh80000000, 32'sh7fffffff});
    drain();
    // inverted box on every axis
    write_box(REG_BOX_MIN_X, q16(1)); write_box(REG_BOX_MAX_X, -q16(1));
    write_box(REG_BOX_MIN_Y, q16(1)); write_box(REG_BOX_MAX_Y, -q16(1));
    write_box(REG_BOX_MIN_Z, q16(1)); write_box(REG_BOX_MAX_Z, -q16(1));
    repeat (40) send_ray(random_ray());
  endtask

  task automatic test_random_boxes();
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      random_box();
      repeat (NUM_RAND / 6) send_ray(random_ray());
    end
  endtask

  // Hold the output long enough for the pipe to fill and block the input
  task automatic test_backpressure();
    drain();
    sender_gaps = 1'b0;
    hold_output = 1'b1;
    fork
      begin
        repeat (LATENCY * 3) @(negedge clk);
        hold_output = 1'b0;
      end
      repeat (LATENCY + 40) send_ray(random_ray());
    join
    sender_gaps = 1'b1;
    drain();
    repeat (30) send_ray(random_ray());
  endtask

  // Receiver: random ready, forced low during the hold-off
  always @(negedge clk) begin
    if (rst || hold_output) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0 ?
                      1'b0 : $urandom_range(0, 1));
  end

  // Compare each output word with the oldest prediction
  always @(posedge clk) begin
    clip_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_clips.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output word at %0t", $time);
      end else begin
        want = pending_clips.pop_front();
        words_checked++;
        if (hit) hits_seen++;
        if (hit !== want.hit || hit_face !== want.face || new_tmax !== want.tmax) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: word %0d hit %b/%b face %0d/%0d tmax %h/%h (exp/act)",
                     words_checked, want.hit, hit, want.face, hit_face,
                     want.tmax, new_tmax);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither side moves a word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst ||
        (pending_clips.size() == 0 && !in_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("ERROR: no progress for %0d cycles", WATCHDOG);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    box_bound = '{-q16(1), q16(1), -q16(1), q16(1), -q16(1), q16(1)};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_box_extremes();
    test_random_boxes();
    test_backpressure();
    drain();
    if (pending_clips.size() != 0) mismatches += pending_clips.size();
    $display("Checked %0d ray words (%0d hits) over reset, extreme, inverted and random boxes,",
             words_checked, hits_seen);
    $display("with random gaps on both sides and a long output stall.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
